// File: design/sra_pkg.sv
// Shared types and constants of the selective-repeat ARQ controller.
package sra_pkg;

    // Fixed field widths of the stream payloads
    localparam int FSEQ_W   = 3;
    localparam int FSLOT_W  = 2;
    localparam int DUR_W    = 16;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 3;
    localparam int APB_A_W  = 3;
    localparam int APB_D_W  = 32;

    localparam logic [DUR_W-1:0] DATA_TO_RESET = 16'd2500;
    localparam logic [DUR_W-1:0] ACK_TO_RESET  = 16'd1000;

    // paddr bit that selects between the two timeout registers
    localparam int REG_SEL_BIT = 2;

    typedef enum logic [2:0] {
        OP_PKT_READY    = 3'd0,
        OP_PHYS_READY   = 3'd1,
        OP_FRAME_RX     = 3'd2,
        OP_DATA_TIMEOUT = 3'd3,
        OP_ACK_TIMEOUT  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        FK_DATA = 2'd0,
        FK_ACK  = 2'd1,
        FK_NAK  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ACT_SEND       = 3'd0,
        ACT_START_DATA = 3'd1,
        ACT_STOP_DATA  = 3'd2,
        ACT_START_ACK  = 3'd3,
        ACT_STOP_ACK   = 3'd4,
        ACT_DELIVER    = 3'd5,
        ACT_GATE       = 3'd6
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SEND,
        S_DTIMER,
        S_STOPACK,
        S_RX_DATA,
        S_MARK,
        S_DELIVER,
        S_DELIV_ACK,
        S_ACKLOOP,
        S_GATE
    } t_state;

    typedef struct packed {
        t_action            action;
        t_kind              tx_kind;
        logic [FSEQ_W-1:0]  tx_seq;
        logic [FSEQ_W-1:0]  tx_ack;
        logic [FSLOT_W-1:0] slot;
        logic [DUR_W-1:0]   duration;
        logic               net_enable;
        logic               last;
    } t_result;

endpackage

// File: design/selective_repeat_arq_controller.sv
// Selective-repeat ARQ control engine: event in, ordered command items out.
//
// The block takes one event item at a time on the s_ stream (opcode in s_tuser) and answers
// with a run of command items on the m_ stream (action in m_tuser), the run closed by a
// network-gate item with m_tlast high. A small sequencer walks the event and produces one
// command item per cycle, unless m_ stalls, into a single output register; a shared
// circular window compare decides the nak retransmit, the receive-window check and each
// step of the ack loop. An event passes through accept and dispatch, then one step per
// command item, plus steps that produce nothing: the nak check (when it naks) and the
// arrival mark on a data frame, the final test of the delivery loop, the final test of
// the ack loop on ack, nak and data frames, and up to NB + 1 search steps on a data
// timeout; m_ stalls hold any step that emits. The longest run, a data frame that
// delivers four slots and retires a full window, carries 14 command items.
// s_tready is high only while the sequencer is idle. Timeout durations come from two APB
// registers: data timeout at 0x0, ack timeout at 0x4 (paddr bit 2 selects, low bits
// ignored).
module selective_repeat_arq_controller #(
    parameter int SEQ_BITS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] frame_good, [2:1] rx_kind, [5:3] rx_ack, [8:6] rx_seq, [10:9] timeout_slot
    input  logic [sra_pkg::S_DATA_W-1:0]    s_tdata,
    // [2:0] opcode
    input  logic [sra_pkg::S_USER_W-1:0]    s_tuser,
    // stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] tx_kind, [4:2] tx_seq, [7:5] tx_ack, [9:8] slot, [25:10] duration,
    // [26] net_enable
    output logic [sra_pkg::M_DATA_W-1:0]    m_tdata,
    // [2:0] action
    output logic [sra_pkg::M_USER_W-1:0]    m_tuser,
    output logic                            m_tlast,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sra_pkg::APB_A_W-1:0]     paddr,
    input  logic [sra_pkg::APB_D_W-1:0]     pwdata,
    output logic [sra_pkg::APB_D_W-1:0]     prdata,
    output logic                            pready
);

    localparam int SW  = SEQ_BITS;
    localparam int SLW = SEQ_BITS - 1;
    localparam int NB  = 2 ** (SEQ_BITS - 1);
    localparam logic [SW-1:0] NB_V = SW'(NB);
    localparam int FSW = sra_pkg::FSEQ_W;
    localparam int FLW = sra_pkg::FSLOT_W;
    localparam int DW  = sra_pkg::DUR_W;

    // ---------------------------------------------------------------- config
    logic [DW-1:0] r_data_to;
    logic [DW-1:0] r_ack_to;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_to <= sra_pkg::DATA_TO_RESET;
            r_ack_to  <= sra_pkg::ACK_TO_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[sra_pkg::REG_SEL_BIT]) begin
                r_ack_to <= pwdata[DW-1:0];
            end else begin
                r_data_to <= pwdata[DW-1:0];
            end
        end
    end

    assign prdata = paddr[sra_pkg::REG_SEL_BIT] ?
                    {(sra_pkg::APB_D_W - DW)'(0), r_ack_to} :
                    {(sra_pkg::APB_D_W - DW)'(0), r_data_to};

    // ---------------------------------------------------------------- input unpack
    logic [SW+FSW-1:0]  w_in_ack_x;
    logic [SW+FSW-1:0]  w_in_seq_x;
    logic [SLW+FLW-1:0] w_in_slot_x;

    assign w_in_ack_x  = {SW'(0), s_tdata[5:3]};
    assign w_in_seq_x  = {SW'(0), s_tdata[8:6]};
    assign w_in_slot_x = {SLW'(0), s_tdata[10:9]};

    // latched event (payload, no reset)
    logic [2:0]     r_op;
    logic           r_good;
    logic [1:0]     r_rx_kind;
    logic [SW-1:0]  r_rx_ack;
    logic [SW-1:0]  r_rx_seq;
    logic [SLW-1:0] r_tslot;

    // ---------------------------------------------------------------- protocol state
    sra_pkg::t_state  r_state, n_state;
    sra_pkg::t_state  r_ret, n_ret;
    sra_pkg::t_kind   r_txkind, n_txkind;
    logic [SW-1:0]    r_seq, n_seq;          // seq of the frame being sent
    logic [SW-1:0]    r_k, n_k;              // data-timeout search step
    logic [SW-1:0]    r_nts, n_nts;          // next_to_send
    logic [SW-1:0]    r_ack_lower, n_ack_lower;
    logic [SW-1:0]    r_recv_lower, n_recv_lower;
    logic [NB-1:0]    r_arrived, n_arrived;
    logic [SW-1:0]    r_outstanding, n_outstanding;
    logic             r_nak_ok, n_nak_ok;
    logic             r_phys, n_phys;

    // output register
    logic             r_mvalid;
    sra_pkg::t_result r_res, n_res;
    logic             w_emit;
    logic             w_can_emit;

    assign w_can_emit = !r_mvalid || m_tready;
    assign s_tready   = (r_state == sra_pkg::S_IDLE);

    // recv_upper always sits NB above recv_lower
    logic [SW-1:0] w_recv_upper;
    logic [SW-1:0] w_want;       // rx_ack + 1, target of a nak
    logic [SW-1:0] w_search_seq; // ack_lower + k
    assign w_recv_upper = r_recv_lower + NB_V;
    assign w_want       = r_rx_ack + SW'(1);
    assign w_search_seq = r_ack_lower + r_k;

    // shared circular window compare: b in [a, c)
    logic [SW-1:0] w_win_a, w_win_b, w_win_c;
    logic          w_win;

    always_comb begin
        w_win_a = r_ack_lower;
        w_win_b = r_rx_ack;
        w_win_c = r_nts;
        if (r_state == sra_pkg::S_DISPATCH) begin
            w_win_b = w_want;
        end else if (r_state == sra_pkg::S_MARK) begin
            w_win_a = r_recv_lower;
            w_win_b = r_rx_seq;
            w_win_c = w_recv_upper;
        end
    end

    assign w_win = ((w_win_a <= w_win_b) && (w_win_b < w_win_c)) ||
                   ((w_win_c < w_win_a) && (w_win_a <= w_win_b)) ||
                   ((w_win_b < w_win_c) && (w_win_c < w_win_a));

    // narrowing / widening to the fixed output fields
    logic [SW+FSW-1:0]  w_txseq_x;
    logic [SW+FSW-1:0]  w_txack_x;
    logic [SLW+FLW-1:0] w_seqslot_x;
    logic [SLW+FLW-1:0] w_dlvslot_x;
    logic [SLW+FLW-1:0] w_ackslot_x;

    assign w_txseq_x   = {FSW'(0), (r_txkind == sra_pkg::FK_DATA) ? r_seq : SW'(0)};
    assign w_txack_x   = {FSW'(0), r_recv_lower - SW'(1)};
    assign w_seqslot_x = {FLW'(0), r_seq[SLW-1:0]};
    assign w_dlvslot_x = {FLW'(0), r_recv_lower[SLW-1:0]};
    assign w_ackslot_x = {FLW'(0), r_ack_lower[SLW-1:0]};

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_txkind      = r_txkind;
        n_seq         = r_seq;
        n_k           = r_k;
        n_nts         = r_nts;
        n_ack_lower   = r_ack_lower;
        n_recv_lower  = r_recv_lower;
        n_arrived     = r_arrived;
        n_outstanding = r_outstanding;
        n_nak_ok      = r_nak_ok;
        n_phys        = r_phys;
        w_emit        = 1'b0;
        n_res         = '0;

        unique case (r_state)
            sra_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_state = sra_pkg::S_DISPATCH;
                end
            end

            sra_pkg::S_DISPATCH: begin
                n_state = sra_pkg::S_GATE;
                unique case (r_op)
                    sra_pkg::OP_PKT_READY: begin
                        if (r_outstanding < NB_V) begin
                            n_outstanding = r_outstanding + SW'(1);
                            n_seq         = r_nts;
                            n_nts         = r_nts + SW'(1);
                            n_txkind      = sra_pkg::FK_DATA;
                            n_ret         = sra_pkg::S_GATE;
                            n_state       = sra_pkg::S_SEND;
                        end
                    end
                    sra_pkg::OP_PHYS_READY: begin
                        n_phys = 1'b1;
                    end
                    sra_pkg::OP_FRAME_RX: begin
                        if (!r_good) begin
                            if (r_nak_ok) begin
                                n_txkind = sra_pkg::FK_NAK;
                                n_seq    = '0;
                                n_ret    = sra_pkg::S_GATE;
                                n_state  = sra_pkg::S_SEND;
                            end
                        end else begin
                            unique case (r_rx_kind)
                                sra_pkg::FK_DATA: n_state = sra_pkg::S_RX_DATA;
                                sra_pkg::FK_ACK:  n_state = sra_pkg::S_ACKLOOP;
                                sra_pkg::FK_NAK: begin
                                    n_state = sra_pkg::S_ACKLOOP;
                                    if (w_win) begin
                                        // retransmit the frame after the nak'd one
                                        n_txkind = sra_pkg::FK_DATA;
                                        n_seq    = w_want;
                                        n_ret    = sra_pkg::S_ACKLOOP;
                                        n_state  = sra_pkg::S_SEND;
                                    end
                                end
                                default: n_state = sra_pkg::S_GATE;
                            endcase
                        end
                    end
                    sra_pkg::OP_DATA_TIMEOUT: begin
                        n_k     = '0;
                        n_state = sra_pkg::S_SEARCH;
                    end
                    sra_pkg::OP_ACK_TIMEOUT: begin
                        n_txkind = sra_pkg::FK_ACK;
                        n_seq    = '0;
                        n_ret    = sra_pkg::S_GATE;
                        n_state  = sra_pkg::S_SEND;
                    end
                    default: n_state = sra_pkg::S_GATE;
                endcase
            end

            // find the outstanding seq that lives in the expired slot
            sra_pkg::S_SEARCH: begin
                if ((r_k < r_outstanding) && (r_k < NB_V)) begin
                    if (w_search_seq[SLW-1:0] == r_tslot) begin
                        n_txkind = sra_pkg::FK_DATA;
                        n_seq    = w_search_seq;
                        n_ret    = sra_pkg::S_GATE;
                        n_state  = sra_pkg::S_SEND;
                    end else begin
                        n_k = r_k + SW'(1);
                    end
                end else begin
                    n_state = sra_pkg::S_GATE;
                end
            end

            sra_pkg::S_SEND: begin
                if (w_can_emit) begin
                    w_emit          = 1'b1;
                    n_res.action    = sra_pkg::ACT_SEND;
                    n_res.tx_kind   = r_txkind;
                    n_res.tx_seq    = w_txseq_x[FSW-1:0];
                    n_res.tx_ack    = w_txack_x[FSW-1:0];
                    n_res.slot      = (r_txkind == sra_pkg::FK_DATA) ?
                                      w_seqslot_x[FLW-1:0] : FLW'(0);
                    n_phys          = 1'b0;
                    if (r_txkind == sra_pkg::FK_NAK) begin
                        n_nak_ok = 1'b0;
                    end
                    n_state = (r_txkind == sra_pkg::FK_DATA) ?
                              sra_pkg::S_DTIMER : sra_pkg::S_STOPACK;
                end
            end

            sra_pkg::S_DTIMER: begin
                if (w_can_emit) begin
                    w_emit         = 1'b1;
                    n_res.action   = sra_pkg::ACT_START_DATA;
                    n_res.slot     = w_seqslot_x[FLW-1:0];
                    n_res.duration = r_data_to;
                    n_state        = sra_pkg::S_STOPACK;
                end
            end

            sra_pkg::S_STOPACK: begin
                if (w_can_emit) begin
                    w_emit       = 1'b1;
                    n_res.action = sra_pkg::ACT_STOP_ACK;
                    n_state      = r_ret;
                end
            end

            // data frame: nak when out of order and a nak is allowed, else arm the ack timer
            sra_pkg::S_RX_DATA: begin
                if ((r_rx_seq != r_recv_lower) && r_nak_ok) begin
                    n_txkind = sra_pkg::FK_NAK;
                    n_seq    = '0;
                    n_ret    = sra_pkg::S_MARK;
                    n_state  = sra_pkg::S_SEND;
                end else if (w_can_emit) begin
                    w_emit         = 1'b1;
                    n_res.action   = sra_pkg::ACT_START_ACK;
                    n_res.duration = r_ack_to;
                    n_state        = sra_pkg::S_MARK;
                end
            end

            sra_pkg::S_MARK: begin
                if (w_win) begin
                    n_arrived[r_rx_seq[SLW-1:0]] = 1'b1;
                end
                n_state = sra_pkg::S_DELIVER;
            end

            sra_pkg::S_DELIVER: begin
                if (r_arrived[r_recv_lower[SLW-1:0]]) begin
                    if (w_can_emit) begin
                        w_emit       = 1'b1;
                        n_res.action = sra_pkg::ACT_DELIVER;
                        n_res.slot   = w_dlvslot_x[FLW-1:0];
                        n_nak_ok     = 1'b1;
                        n_arrived[r_recv_lower[SLW-1:0]] = 1'b0;
                        n_recv_lower = r_recv_lower + SW'(1);
                        n_state      = sra_pkg::S_DELIV_ACK;
                    end
                end else begin
                    n_state = sra_pkg::S_ACKLOOP;
                end
            end

            sra_pkg::S_DELIV_ACK: begin
                if (w_can_emit) begin
                    w_emit         = 1'b1;
                    n_res.action   = sra_pkg::ACT_START_ACK;
                    n_res.duration = r_ack_to;
                    n_state        = sra_pkg::S_DELIVER;
                end
            end

            // cumulative ack: retire frames up to rx_ack
            sra_pkg::S_ACKLOOP: begin
                if (w_win) begin
                    if (w_can_emit) begin
                        w_emit       = 1'b1;
                        n_res.action = sra_pkg::ACT_STOP_DATA;
                        n_res.slot   = w_ackslot_x[FLW-1:0];
                        if (r_outstanding != '0) begin
                            n_outstanding = r_outstanding - SW'(1);
                        end
                        n_ack_lower = r_ack_lower + SW'(1);
                    end
                end else begin
                    n_state = sra_pkg::S_GATE;
                end
            end

            sra_pkg::S_GATE: begin
                if (w_can_emit) begin
                    w_emit           = 1'b1;
                    n_res.action     = sra_pkg::ACT_GATE;
                    n_res.net_enable = (r_outstanding < NB_V) && r_phys;
                    n_res.last       = 1'b1;
                    n_state          = sra_pkg::S_IDLE;
                end
            end

            default: n_state = sra_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sra_pkg::S_IDLE;
            r_ret         <= sra_pkg::S_GATE;
            r_txkind      <= sra_pkg::FK_DATA;
            r_seq         <= '0;
            r_k           <= '0;
            r_nts         <= '0;
            r_ack_lower   <= '0;
            r_recv_lower  <= '0;
            r_arrived     <= '0;
            r_outstanding <= '0;
            r_nak_ok      <= 1'b1;
            r_phys        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ret         <= n_ret;
            r_txkind      <= n_txkind;
            r_seq         <= n_seq;
            r_k           <= n_k;
            r_nts         <= n_nts;
            r_ack_lower   <= n_ack_lower;
            r_recv_lower  <= n_recv_lower;
            r_arrived     <= n_arrived;
            r_outstanding <= n_outstanding;
            r_nak_ok      <= n_nak_ok;
            r_phys        <= n_phys;
        end
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_op      <= s_tuser;
            r_good    <= s_tdata[0];
            r_rx_kind <= s_tdata[2:1];
            r_rx_ack  <= w_in_ack_x[SW-1:0];
            r_rx_seq  <= w_in_seq_x[SW-1:0];
            r_tslot   <= w_in_slot_x[SLW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_emit) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res <= n_res;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tuser  = r_res.action;
    assign m_tlast  = r_res.last;
    assign m_tdata  = {5'b0, r_res.net_enable, r_res.duration, r_res.slot,
                       r_res.tx_ack, r_res.tx_seq, r_res.tx_kind};

    // ---------------------------------------------------------------- assertions
    a_last_on_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == sra_pkg::ACT_GATE)))
        else $error("tlast not tied to the gate item");

    a_outstanding_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding == SW'(r_nts - r_ack_lower))
        else $error("outstanding count out of step with the send window");

    a_outstanding_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= NB_V)
        else $error("outstanding count above window size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second event accepted while busy");

endmodule

// File: tb/selective_repeat_arq_controller_test.sv
// Self-checking testbench for the selective-repeat ARQ controller: predicted command runs.
module selective_repeat_arq_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Sequence space and window: 3-bit numbers, four slots
    localparam int WINDOW = 4;
    // APB register map: one register per 32-bit word
    localparam int REG_DATA_TO = 0;
    localparam int REG_ACK_TO  = 1;
    localparam int REG_STRIDE  = 4;
    // Codes outside the defined sets; the block must ignore them
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [1:0] FK_RESERVED  = 2'd3;
    // Longest event: full window released plus deliveries
    localparam int SETTLE_CYCLES = 30;

    // One event item as it travels on the s_ stream
    typedef struct packed {
        logic [2:0] op;
        logic       good;
        logic [1:0] kind;
        logic [2:0] ack;
        logic [2:0] seq;
        logic [1:0] tslot;
    } t_arq_event;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // [0] good, [2:1] kind, [5:3] ack, [8:6] seq, [10:9] tslot
    logic [sra_pkg::S_DATA_W-1:0]  s_tdata;
    logic [sra_pkg::S_USER_W-1:0]  s_tuser;   // [2:0] opcode
    logic                          m_tvalid;
    logic                          m_tready;
    // [1:0] kind, [4:2] seq, [7:5] ack, [9:8] slot, [25:10] duration, [26] net_enable
    logic [sra_pkg::M_DATA_W-1:0]  m_tdata;
    logic [sra_pkg::M_USER_W-1:0]  m_tuser;   // [2:0] action
    logic                          m_tlast;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sra_pkg::APB_A_W-1:0]   paddr;
    logic [sra_pkg::APB_D_W-1:0]   pwdata;
    logic [sra_pkg::APB_D_W-1:0]   prdata;
    logic                          pready;

    // Shadow of the controller: sender window, receiver window, flags and timer settings
    logic [2:0]  tx_next      = 3'd0;
    logic [2:0]  tx_base      = 3'd0;
    logic [2:0]  rx_base      = 3'd0;
    logic [2:0]  rx_top       = 3'(WINDOW);
    logic        rx_held [WINDOW];
    int          tx_in_flight = 0;
    logic        nak_armed    = 1'b1;
    logic        phy_ok       = 1'b0;
    logic [15:0] data_dur     = sra_pkg::DATA_TO_RESET;
    logic [15:0] ack_dur      = sra_pkg::ACK_TO_RESET;

    sra_pkg::t_result pending_cmds[$];   // commands still owed by the block, oldest first
    int          n_errors = 0;
    bit          steady   = 1'b0;   // 1: no gaps from the sender, no stalls from the receiver

    selective_repeat_arq_controller uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("selective_repeat_arq_controller_test: errors");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    // b within the circular interval [a, c)
    function automatic bit seq_between(logic [2:0] a, logic [2:0] b, logic [2:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic void expect_cmd(sra_pkg::t_action act, sra_pkg::t_kind kind,
                                       logic [2:0] sq, logic [2:0] ak, logic [1:0] sl,
                                       logic [15:0] dur, logic en, logic lst);
        sra_pkg::t_result r;
        r.action     = act;
        r.tx_kind    = kind;
        r.tx_seq     = sq;
        r.tx_ack     = ak;
        r.slot       = sl;
        r.duration   = dur;
        r.net_enable = en;
        r.last       = lst;
        pending_cmds.push_back(r);
    endfunction

    // Frame out: send, data timer start for data frames, ack timer stop.
    // Every frame piggybacks the last in-order sequence received.
    function automatic void model_send(sra_pkg::t_kind kind, logic [2:0] sq);
        logic [1:0] sl;
        sl = (kind == sra_pkg::FK_DATA) ? sq[1:0] : 2'd0;
        expect_cmd(sra_pkg::ACT_SEND, kind, (kind == sra_pkg::FK_DATA) ? sq : 3'd0,
                   rx_base - 3'd1, sl, 16'd0, 1'b0, 1'b0);
        phy_ok = 1'b0;
        if (kind == sra_pkg::FK_DATA)
            expect_cmd(sra_pkg::ACT_START_DATA, sra_pkg::FK_DATA, 3'd0, 3'd0, sl, data_dur,
                       1'b0, 1'b0);
        if (kind == sra_pkg::FK_NAK)
            nak_armed = 1'b0;
        expect_cmd(sra_pkg::ACT_STOP_ACK, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0, 16'd0,
                   1'b0, 1'b0);
    endfunction

    // Good frame in: nak retransmit, receive side with in-order delivery, then ack release
    function automatic void model_frame(sra_pkg::t_kind kind, logic [2:0] ak, logic [2:0] sq);
        logic [2:0] want;
        if (kind == sra_pkg::FK_NAK) begin
            want = ak + 3'd1;
            if (seq_between(tx_base, want, tx_next))
                model_send(sra_pkg::FK_DATA, want);
        end
        if (kind == sra_pkg::FK_DATA) begin
            if (sq != rx_base && nak_armed)
                model_send(sra_pkg::FK_NAK, 3'd0);
            else
                expect_cmd(sra_pkg::ACT_START_ACK, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0,
                           ack_dur, 1'b0, 1'b0);
            if (seq_between(rx_base, sq, rx_top) && !rx_held[sq[1:0]])
                rx_held[sq[1:0]] = 1'b1;
            while (rx_held[rx_base[1:0]]) begin
                expect_cmd(sra_pkg::ACT_DELIVER, sra_pkg::FK_DATA, 3'd0, 3'd0, rx_base[1:0],
                           16'd0, 1'b0, 1'b0);
                nak_armed = 1'b1;
                rx_held[rx_base[1:0]] = 1'b0;
                rx_base = rx_base + 3'd1;
                rx_top  = rx_top + 3'd1;
                expect_cmd(sra_pkg::ACT_START_ACK, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0,
                           ack_dur, 1'b0, 1'b0);
            end
        end
        // cumulative ack: release every slot up to and including ak
        while (seq_between(tx_base, ak, tx_next)) begin
            if (tx_in_flight > 0)
                tx_in_flight--;
            expect_cmd(sra_pkg::ACT_STOP_DATA, sra_pkg::FK_DATA, 3'd0, 3'd0, tx_base[1:0],
                       16'd0, 1'b0, 1'b0);
            tx_base = tx_base + 3'd1;
        end
    endfunction

    // Whole command run for one accepted event, closed by the gate item
    function automatic void model_event(t_arq_event ev);
        int         k;
        logic [2:0] s;
        case (ev.op)
            sra_pkg::OP_PKT_READY: begin
                if (tx_in_flight < WINDOW) begin
                    tx_in_flight++;
                    model_send(sra_pkg::FK_DATA, tx_next);
                    tx_next = tx_next + 3'd1;
                end
            end
            sra_pkg::OP_PHYS_READY: phy_ok = 1'b1;
            sra_pkg::OP_FRAME_RX: begin
                if (!ev.good) begin
                    if (nak_armed)
                        model_send(sra_pkg::FK_NAK, 3'd0);
                end else if (ev.kind != FK_RESERVED) begin
                    model_frame(sra_pkg::t_kind'(ev.kind), ev.ack, ev.seq);
                end
            end
            sra_pkg::OP_DATA_TIMEOUT: begin
                // retransmit the outstanding sequence that occupies the expired slot
                for (k = 0; k < tx_in_flight && k < WINDOW; k++) begin
                    s = tx_base + 3'(k);
                    if (s[1:0] == ev.tslot) begin
                        model_send(sra_pkg::FK_DATA, s);
                        break;
                    end
                end
            end
            sra_pkg::OP_ACK_TIMEOUT: model_send(sra_pkg::FK_ACK, 3'd0);
            default: ;
        endcase
        expect_cmd(sra_pkg::ACT_GATE, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0, 16'd0,
                   (tx_in_flight < WINDOW) && phy_ok, 1'b1);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Every accepted command item is matched against the oldest prediction
    always @(posedge i_clk) begin : cmd_check
        sra_pkg::t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command item, expected none got action %0d data %h",
                         $time, m_tuser, m_tdata);
                n_errors++;
            end else begin
                want = pending_cmds.pop_front();
                check_field("action", want.action, m_tuser);
                check_field("tx_kind", want.tx_kind, m_tdata[1:0]);
                check_field("tx_seq", want.tx_seq, m_tdata[4:2]);
                check_field("tx_ack", want.tx_ack, m_tdata[7:5]);
                check_field("slot", want.slot, m_tdata[9:8]);
                check_field("duration", want.duration, m_tdata[25:10]);
                check_field("net_enable", want.net_enable, m_tdata[26]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 2);
        if (r < 18)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Receiver back-pressure; stalls land anywhere in a command run
    initial begin : ready_gen
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    function automatic t_arq_event ev_of(logic [2:0] op, logic good, logic [1:0] kind,
                                         logic [2:0] ak, logic [2:0] sq, logic [1:0] ts);
        t_arq_event ev;
        ev.op    = op;
        ev.good  = good;
        ev.kind  = kind;
        ev.ack   = ak;
        ev.seq   = sq;
        ev.tslot = ts;
        return ev;
    endfunction

    // Offer one event item, wait for the handshake, then predict its command run
    task automatic send_event(input t_arq_event ev);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tuser  = ev.op;
        s_tdata  = {5'd0, ev.tslot, ev.seq, ev.ack, ev.kind, ev.good};
        do @(posedge i_clk); while (!s_tready);
        model_event(ev);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        s_tdata  = 16'($urandom);   // junk on the bus while nothing is offered
        s_tuser  = 3'($urandom);
    endtask

    // Mostly well-formed traffic steered by the shadow windows; a few ignored items.
    // Returns 0 for items the block ignores.
    function automatic bit make_event(output t_arq_event ev);
        int r;
        int k;
        ev = ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'($urandom), 3'($urandom),
                   2'($urandom));
        r = $urandom_range(0, 99);
        if (r < 22) begin
            ev.op = sra_pkg::OP_PKT_READY;
        end else if (r < 34) begin
            ev.op = sra_pkg::OP_PHYS_READY;
        end else if (r < 78) begin
            ev.good = ($urandom_range(0, 9) != 0);
            k = $urandom_range(0, 9);
            ev.kind = (k < 6) ? sra_pkg::FK_DATA : (k < 8) ? sra_pkg::FK_ACK : sra_pkg::FK_NAK;
            // seq mostly inside the receive window, ack around the send window
            if ($urandom_range(0, 7) != 0)
                ev.seq = rx_base + 3'($urandom_range(0, WINDOW));
            if ($urandom_range(0, 7) != 0)
                ev.ack = tx_base + 3'($urandom_range(0, WINDOW)) - 3'd1;
        end else if (r < 88) begin
            ev.op = sra_pkg::OP_DATA_TIMEOUT;
        end else if (r < 94) begin
            ev.op = sra_pkg::OP_ACK_TIMEOUT;
        end else begin
            if ($urandom_range(0, 1) != 0)
                ev.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                ev.kind = FK_RESERVED;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic run_traffic(input int n);
        t_arq_event ev;
        int         done;
        done = 0;
        while (done < n) begin
            if (make_event(ev))
                done++;
            send_event(ev);
        end
    endtask

    // Block idle: all predictions met, plus slack for the sequencer to return home
    task automatic wait_drained();
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [15:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = sra_pkg::APB_A_W'(idx * REG_STRIDE);
        pwdata  = {16'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_DATA_TO)
            data_dur = val;
        else
            ack_dur = val;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_check(input int idx);
        logic [31:0] want;
        want = {16'd0, (idx == REG_DATA_TO) ? data_dur : ack_dur};
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = sra_pkg::APB_A_W'(idx * REG_STRIDE);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", want, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // Timer registers come out of reset at their defaults
    task automatic test_reset_defaults();
        cfg_check(REG_DATA_TO);
        cfg_check(REG_ACK_TO);
    endtask

    // Hand-built walk through the protocol corners, at reset durations
    task automatic test_protocol_cases();
        int op;
        send_event(ev_of(sra_pkg::OP_PHYS_READY, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0));
        // fill the window; the fifth packet finds it full and only gets the gate
        repeat (WINDOW + 1)
            send_event(ev_of(sra_pkg::OP_PKT_READY, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0));
        // data timer on slot 2 resends sequence 2
        send_event(ev_of(sra_pkg::OP_DATA_TIMEOUT, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd2));
        // nak for 0: resend 1, and 0 counts as acked
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_NAK, 3'd0, 3'd0, 2'd0));
        // cumulative ack empties the window
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_ACK, 3'd3, 3'd0, 2'd0));
        // timer expiry on a slot with nothing outstanding
        send_event(ev_of(sra_pkg::OP_DATA_TIMEOUT, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd1));
        // out-of-order data: nak and hold it
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd1, 2'd0));
        // damaged frame while a nak is already out: nothing
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0));
        // the gap fills: deliver 0 and 1
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd0, 2'd0));
        // damaged frame after delivery re-armed the nak
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0));
        send_event(ev_of(sra_pkg::OP_ACK_TIMEOUT, 1'b0, sra_pkg::FK_DATA, 3'd0, 3'd0, 2'd0));
        // unknown frame kind and unknown opcodes are dropped
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, FK_RESERVED, 3'd0, 3'd0, 2'd0));
        for (op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_event(ev_of(3'(op), 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd7, 2'd3));
        // field extremes: sequence 7 lies outside the receive window
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd7, 2'd3));
        // three frames ahead, then the missing one releases all four slots
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd5, 2'd0));
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd4, 2'd0));
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd3, 2'd0));
        send_event(ev_of(sra_pkg::OP_FRAME_RX, 1'b1, sra_pkg::FK_DATA, 3'd7, 3'd2, 2'd0));
    endtask

    // Traffic under minimum, maximum and arbitrary timer durations
    task automatic test_timer_settings();
        logic [15:0] data_vals [3];
        logic [15:0] ack_vals [3];
        int          i;
        data_vals = '{16'd1, 16'd65535, 16'($urandom_range(2, 65534))};
        ack_vals  = '{16'd65535, 16'd1, 16'($urandom_range(2, 65534))};
        for (i = 0; i < 3; i++) begin
            wait_drained();
            cfg_write(REG_DATA_TO, data_vals[i]);
            cfg_write(REG_ACK_TO, ack_vals[i]);
            cfg_check(REG_DATA_TO);
            cfg_check(REG_ACK_TO);
            run_traffic(20);
        end
    endtask

    // Back-to-back items, receiver always ready
    task automatic test_steady_stream();
        steady = 1'b1;
        run_traffic(25);
        steady = 1'b0;
    endtask

    // Short bursts, each followed by a full drain of the command stream
    task automatic test_drain_pauses();
        repeat (5) begin
            run_traffic(5);
            wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(30);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        foreach (rx_held[i])
            rx_held[i] = 1'b0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_protocol_cases();
        test_timer_settings();
        test_steady_stream();
        test_drain_pauses();
        test_random_traffic();

        wait_drained();
        if (n_errors == 0)
            $display("selective_repeat_arq_controller_test: clean");
        else
            $display("selective_repeat_arq_controller_test: errors");
        $finish;
    end

endmodule

// File: filelist.f
design/sra_pkg.sv
design/selective_repeat_arq_controller.sv
tb/selective_repeat_arq_controller_test.sv
